>>> design/tdb_pkg.sv
// Shared types and constants for the timed input debouncer.
// No dependencies; imported by every module in the design folder.
`default_nettype none
package tdb_pkg;

	localparam int SAMPLE_BITS = 10;
	localparam int NUM_BUTTONS = 4;
	localparam int MS_BITS     = 16;
	localparam int TIME_BITS   = 32;
	localparam int LVL_BITS    = 11;
	localparam int IN_BITS     = 10;

	localparam logic [MS_BITS-1:0] SAT16 = 16'hFFFF;

	localparam logic [1:0] MODE_UPDATE = 2'd0;
	localparam logic [1:0] MODE_TAKE   = 2'd1;
	localparam logic [1:0] MODE_INIT   = 2'd2;

	localparam logic [1:0] CFG_DEBOUNCE = 2'd0;
	localparam logic [1:0] CFG_PERIOD   = 2'd1;
	localparam logic [1:0] CFG_THRESH   = 2'd2;

	localparam int BTN_SW1   = 0;
	localparam int BTN_LEFT  = 1;
	localparam int BTN_RIGHT = 2;
	localparam int BTN_SW2   = 3;

	typedef logic [MS_BITS-1:0]     ms_t;
	typedef logic [TIME_BITS-1:0]   time_t;
	typedef logic [SAMPLE_BITS-1:0] sample_t;

	typedef struct packed {
		logic stable;
		ms_t  mismatch;
		logic rose;
	} lane_res_t;

	typedef struct packed {
		logic [1:0]         events;
		logic [2:0]         switch_mask;
		logic [IN_BITS-1:0] speed_level;
	} res_t;

endpackage
`default_nettype wire

>>> design/tdb_lane.sv
// One debounce lane: saturating mismatch sum and stable-state adoption.
// Depends on tdb_pkg.
`default_nettype none
module tdb_lane
	import tdb_pkg::*;
(
	input  wire logic      en,
	input  wire logic      raw,
	input  wire logic      stable,
	input  wire ms_t       mismatch,
	input  wire time_t     gap,
	input  wire ms_t       debounce_ms,
	output lane_res_t      res
);

	ms_t              room;
	logic [MS_BITS:0] sum;
	ms_t              acc;

	always_comb begin
		room = SAT16 - mismatch;
		sum  = {1'b0, mismatch} + {1'b0, gap[MS_BITS-1:0]};
		acc  = (gap > {{(TIME_BITS-MS_BITS){1'b0}}, room}) ? SAT16 : sum[MS_BITS-1:0];
		res.stable   = stable;
		res.mismatch = mismatch;
		res.rose     = 1'b0;
		if (en) begin
			if (raw == stable) begin
				res.mismatch = '0;
			end else if (acc >= debounce_ms) begin
				res.stable   = raw;
				res.mismatch = '0;
				res.rose     = raw;
			end else begin
				res.mismatch = acc;
			end
		end
	end

endmodule
`default_nettype wire

>>> design/tdb_ema.sv
// Speed smoothing step: avg*7/8 + raw/8 in integer form.
// Depends on tdb_pkg.
`default_nettype none
module tdb_ema
	import tdb_pkg::*;
(
	input  wire sample_t avg,
	input  wire sample_t raw,
	output sample_t      avg_next
);

	logic [SAMPLE_BITS+2:0] sum;

	always_comb begin
		sum = ({avg, 3'b000} - {3'b000, avg}) + {3'b000, raw};
		avg_next = sum[SAMPLE_BITS+2:3];
	end

endmodule
`default_nettype wire

>>> design/tdb_obuf.sv
// Result output register with a skid entry so input ready is registered.
// Depends on tdb_pkg.
`default_nettype none
module tdb_obuf
	import tdb_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic push,
	input  wire res_t push_data,
	output logic      push_ready,
	output logic      out_valid,
	input  wire logic out_ready,
	output res_t      out_data
);

	res_t out_q;
	res_t skid_q;
	logic out_valid_q;
	logic skid_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (out_ready || !out_valid_q) begin
			if (skid_valid_q) begin
				out_valid_q  <= 1'b1;
				skid_valid_q <= 1'b0;
			end else begin
				out_valid_q <= push;
			end
		end else if (push) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_ready || !out_valid_q) begin
			if (skid_valid_q) begin
				out_q <= skid_q;
			end else if (push) begin
				out_q <= push_data;
			end
		end else if (push) begin
			skid_q <= push_data;
		end
	end

	assign push_ready = !skid_valid_q;
	assign out_valid  = out_valid_q;
	assign out_data   = out_q;

endmodule
`default_nettype wire

>>> design/timed_input_debouncer_top.sv
// Top level of the timed input debouncer: state, lanes, merge and output buffer.
// Depends on tdb_pkg, tdb_lane, tdb_ema and tdb_obuf.
`default_nettype none
// Takes one item per clock while in_ready is high and returns one result per item, held
// in the output buffer until out_ready. The whole state update for an item (elapsed-time
// subtract, four button lanes and the third-switch lane side by side, the speed filter) is
// combinational, so items can follow back to back; a two-entry output buffer decouples the
// result side. Configuration writes are always accepted and take effect on the next item.
module timed_input_debouncer_top
	import tdb_pkg::*;
(
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   in_valid,
	output logic                        in_ready,
	input  wire logic [1:0]             mode,
	input  wire logic [TIME_BITS-1:0]   now_ms,
	input  wire logic [NUM_BUTTONS-1:0] buttons_pressed,
	input  wire logic [IN_BITS-1:0]     speed_sample,
	input  wire logic [IN_BITS-1:0]     level_sample,
	output logic                        out_valid,
	input  wire logic                   out_ready,
	output logic [1:0]                  events,
	output logic [2:0]                  switch_mask,
	output logic [IN_BITS-1:0]          speed_level,
	input  wire logic                   cfg_valid,
	output logic                        cfg_ready,
	input  wire logic [1:0]             cfg_index,
	input  wire logic [MS_BITS-1:0]     cfg_data
);

	ms_t                  debounce_q;
	ms_t                  period_q;
	logic [LVL_BITS-1:0]  thresh_q;
	time_t                last_upd_q;
	time_t                last_an_q;
	logic [1:0]           pending_q;
	sample_t              avg_q;
	logic                 third_on_q;
	ms_t                  third_mis_q;
	logic [NUM_BUTTONS-1:0] stable_q;
	ms_t                  mis_q [NUM_BUTTONS];

	logic                 accept;
	time_t                elapsed;
	time_t                an_gap;
	logic                 upd_go;
	logic                 an_go;
	sample_t              speed_in;
	sample_t              level_in;
	sample_t              avg_ema;
	logic                 level_on;
	lane_res_t            btn_res [NUM_BUTTONS];
	lane_res_t            third_res;

	logic [1:0]             pending_d;
	sample_t                avg_d;
	logic                   third_on_d;
	logic [NUM_BUTTONS-1:0] stable_d;
	res_t                   res_d;
	res_t                   res_out;

	assign cfg_ready = 1'b1;
	assign accept    = in_valid && in_ready;
	assign speed_in  = SAMPLE_BITS'(speed_sample);
	assign level_in  = SAMPLE_BITS'(level_sample);
	assign elapsed   = now_ms - last_upd_q;
	assign an_gap    = now_ms - last_an_q;
	assign upd_go    = (mode == MODE_UPDATE) && (elapsed != '0);
	assign an_go     = upd_go && (an_gap >= {{(TIME_BITS-MS_BITS){1'b0}}, period_q});
	assign level_on  = {{(LVL_BITS+16-SAMPLE_BITS){1'b0}}, level_in} <
		{16'b0, thresh_q};

	for (genvar i = 0; i < NUM_BUTTONS; i++) begin : g_lane
		tdb_lane u_lane (
			.en          (upd_go),
			.raw         (buttons_pressed[i]),
			.stable      (stable_q[i]),
			.mismatch    (mis_q[i]),
			.gap         (elapsed),
			.debounce_ms (debounce_q),
			.res         (btn_res[i])
		);
	end

	tdb_lane u_third (
		.en          (an_go),
		.raw         (level_on),
		.stable      (third_on_q),
		.mismatch    (third_mis_q),
		.gap         (an_gap),
		.debounce_ms (debounce_q),
		.res         (third_res)
	);

	tdb_ema u_ema (
		.avg      (avg_q),
		.raw      (speed_in),
		.avg_next (avg_ema)
	);

	// merge lanes into next state and the result item
	always_comb begin
		pending_d  = pending_q;
		avg_d      = avg_q;
		third_on_d = third_on_q;
		for (int i = 0; i < NUM_BUTTONS; i++) begin
			stable_d[i] = stable_q[i];
		end
		res_d.events = pending_q;
		case (mode)
			MODE_UPDATE: begin
				pending_d = pending_q | {btn_res[BTN_RIGHT].rose, btn_res[BTN_LEFT].rose};
				if (an_go) begin
					avg_d = avg_ema;
				end
				third_on_d = third_res.stable;
				for (int i = 0; i < NUM_BUTTONS; i++) begin
					stable_d[i] = btn_res[i].stable;
				end
				res_d.events = pending_d;
			end
			MODE_TAKE: begin
				pending_d = '0;
			end
			MODE_INIT: begin
				avg_d      = speed_in;
				third_on_d = level_on;
				stable_d   = buttons_pressed;
			end
			default: begin
			end
		endcase
		res_d.switch_mask = {third_on_d, stable_d[BTN_SW2], stable_d[BTN_SW1]};
		res_d.speed_level = IN_BITS'(avg_d);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			debounce_q <= 16'd30;
			period_q   <= 16'd20;
			thresh_q   <= 11'd512;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_DEBOUNCE: debounce_q <= cfg_data;
				CFG_PERIOD:   period_q   <= cfg_data;
				CFG_THRESH:   thresh_q   <= cfg_data[LVL_BITS-1:0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_upd_q  <= '0;
			last_an_q   <= '0;
			pending_q   <= '0;
			avg_q       <= '0;
			third_on_q  <= 1'b0;
			third_mis_q <= '0;
			stable_q    <= '0;
			for (int i = 0; i < NUM_BUTTONS; i++) begin
				mis_q[i] <= '0;
			end
		end else if (accept) begin
			pending_q  <= pending_d;
			avg_q      <= avg_d;
			third_on_q <= third_on_d;
			stable_q   <= stable_d;
			if (upd_go) begin
				last_upd_q <= now_ms;
			end
			if (an_go) begin
				last_an_q <= now_ms;
			end
			if (mode == MODE_UPDATE) begin
				third_mis_q <= third_res.mismatch;
			end
			for (int i = 0; i < NUM_BUTTONS; i++) begin
				if (mode == MODE_INIT) begin
					mis_q[i] <= '0;
				end else if (mode == MODE_UPDATE) begin
					mis_q[i] <= btn_res[i].mismatch;
				end
			end
		end
	end

	tdb_obuf u_obuf (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (accept),
		.push_data  (res_d),
		.push_ready (in_ready),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_data   (res_out)
	);

	assign events      = res_out.events;
	assign switch_mask = res_out.switch_mask;
	assign speed_level = res_out.speed_level;

endmodule
`default_nettype wire
